@@ src/tzbh_pkg.sv @@
`timescale 1ns / 1ps

package tzbh_pkg;

    // field and datapath widths
    localparam int COORD_W = 12;
    localparam int NUM_W   = 2 * COORD_W;
    localparam int SX_W    = 8;
    localparam int SY_W    = 9;
    localparam int CFG_W   = 16;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int FLAGS_W = 3;

    // default screen size
    localparam int SCREEN_WIDTH_DEF  = 240;
    localparam int SCREEN_HEIGHT_DEF = 320;

    // calibration flag bit positions
    localparam int FLAG_SWAP  = 0;
    localparam int FLAG_INV_X = 1;
    localparam int FLAG_INV_Y = 2;

    // register reset values
    localparam logic [COORD_W-1:0] CAL_MAX_RST    = 12'd4095;
    localparam logic [HOLD_W-1:0]  HOLD_LIMIT_RST = 16'd2000;

    typedef enum logic [1:0] {
        ZONE_UP     = 2'd0,
        ZONE_SELECT = 2'd1,
        ZONE_DOWN   = 2'd2,
        ZONE_NONE   = 2'd3
    } zone_t;

    typedef enum logic [1:0] {
        MODE_TOUCH    = 2'd0,
        MODE_PIN_LOW  = 2'd1,
        MODE_PIN_HIGH = 2'd2,
        MODE_OFF      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_CAL_X_MIN    = 3'd0,
        REG_CAL_X_MAX    = 3'd1,
        REG_CAL_Y_MIN    = 3'd2,
        REG_CAL_Y_MAX    = 3'd3,
        REG_CAL_FLAGS    = 3'd4,
        REG_HOLD_LIMIT   = 3'd5,
        REG_WATCHED_ZONE = 3'd6,
        REG_INPUT_MODE   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    // button event flags from the press tracker
    typedef struct packed {
        logic jp;
        logic jr;
        logic held;
    } btn_flags_t;

endpackage

@@ src/tzbh_div.sv @@
`timescale 1ns / 1ps

module tzbh_div
    import tzbh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   dividend,
    input  logic [COORD_W-1:0] divisor,
    output logic               done,
    output logic [NUM_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0]   quo_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [COORD_W:0]   rem_shift;
    logic               fits;
    logic [COORD_W:0]   rem_sub;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[COORD_W-1:0] : rem_shift[COORD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/tzbh_btn.sv @@
`timescale 1ns / 1ps

module tzbh_btn
    import tzbh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  logic              touched,
    input  zone_t             zone,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    input  mode_t             input_mode,
    input  logic [1:0]        watched_zone,
    input  logic [HOLD_W-1:0] hold_limit,
    output btn_flags_t        flags
);

    logic              was_pressed_reg;
    logic [TIME_W-1:0] press_start_reg;
    logic              btn;
    logic [TIME_W-1:0] elapsed;

    // button level from the selected source
    always_comb
    begin
        case (input_mode)
            MODE_TOUCH:    btn = touched && (zone == zone_t'(watched_zone));
            MODE_PIN_LOW:  btn = !pin_level;
            MODE_PIN_HIGH: btn = pin_level;
            default:       btn = 1'b0;
        endcase
    end

    // edges and hold check, elapsed time wraps
    always_comb
    begin
        elapsed    = now_ms - press_start_reg;
        flags.jp   = btn && !was_pressed_reg;
        flags.jr   = !btn && was_pressed_reg;
        flags.held = btn && was_pressed_reg && (elapsed >= TIME_W'(hold_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            press_start_reg <= '0;
        end
        else if (update)
        begin
            was_pressed_reg <= btn;
            if (flags.jp)
            begin
                press_start_reg <= now_ms;
            end
        end
    end

endmodule

@@ src/touch_zone_button_hold_detector.sv @@
`timescale 1ns / 1ps
// channel | handshake            | fields
// input   | in_valid, in_stall   | touched, raw_x, raw_y, pin_level, now_ms
// output  | out_valid, out_stall | just_pressed, just_released, held, screen_x, screen_y, zone
// config  | cfg_wr_en            | cfg_index, cfg_wr_data
//
// A touched sample runs each axis through multiply, divider start, a wait on
// the shared radix-2 divider, then sign, invert and clamp. A sample with no
// touch goes straight to output; a zero-span axis skips the divider.
// One sample at a time; in_stall is high from acceptance until the result
// is loaded into the output register, which waits while a valid result is stalled.
// Reset (rst_n, asynchronous) restores calibration defaults and release.

module touch_zone_button_hold_detector
    import tzbh_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    // sample in
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              touched,
    input  logic [COORD_W-1:0] raw_x,
    input  logic [COORD_W-1:0] raw_y,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    // result out
    output logic              out_valid,
    input  logic              out_stall,
    output logic              just_pressed,
    output logic              just_released,
    output logic              held,
    output logic [SX_W-1:0]   screen_x,
    output logic [SY_W-1:0]   screen_y,
    output logic [1:0]        zone
);

    localparam int EXT_W = NUM_W + 2;
    localparam logic [COORD_W-1:0] X_LAST  = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST  = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [COORD_W-1:0] THIRD_1 = COORD_W'(SCREEN_HEIGHT / 3);
    localparam logic [COORD_W-1:0] THIRD_2 = COORD_W'((SCREEN_HEIGHT / 3) * 2);

    // configuration registers
    logic [COORD_W-1:0] cal_x_min_reg;
    logic [COORD_W-1:0] cal_x_max_reg;
    logic [COORD_W-1:0] cal_y_min_reg;
    logic [COORD_W-1:0] cal_y_max_reg;
    logic [FLAGS_W-1:0] cal_flags_reg;
    logic [HOLD_W-1:0]  hold_limit_reg;
    logic [1:0]         watched_zone_reg;
    mode_t              input_mode_reg;

    // sequencer and sample registers
    state_t             state_reg;
    state_t             state_next;
    logic               touched_reg;
    logic [COORD_W-1:0] rx_reg;
    logic [COORD_W-1:0] ry_reg;
    logic               pin_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               axis_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic               sign_reg;
    logic               zspan_reg;
    logic [COORD_W-1:0] span_reg;
    logic [COORD_W-1:0] sx_reg;
    logic [COORD_W-1:0] sy_reg;

    // output register
    logic               out_valid_reg;
    btn_flags_t         out_flags_reg;
    logic [SX_W-1:0]    out_sx_reg;
    logic [SY_W-1:0]    out_sy_reg;
    zone_t              out_zone_reg;

    logic               accept;
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quo;
    logic               load_out;

    logic [COORD_W-1:0] ax_raw;
    logic [COORD_W-1:0] ax_lo;
    logic [COORD_W-1:0] ax_hi;
    logic [COORD_W-1:0] ax_last;
    logic               ax_inv;
    logic [COORD_W:0]   diff;
    logic [COORD_W:0]   span;
    logic [COORD_W-1:0] diff_mag;
    logic [COORD_W-1:0] span_mag;

    logic [NUM_W-1:0]   q_sel;
    logic signed [EXT_W-1:0] v_sgn;
    logic signed [EXT_W-1:0] v_inv;
    logic signed [EXT_W-1:0] last_ext;
    logic [COORD_W-1:0] coord;

    zone_t              zone_cur;
    btn_flags_t         btn_flags;

    assign accept = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_x_min_reg    <= '0;
            cal_x_max_reg    <= CAL_MAX_RST;
            cal_y_min_reg    <= '0;
            cal_y_max_reg    <= CAL_MAX_RST;
            cal_flags_reg    <= '0;
            hold_limit_reg   <= HOLD_LIMIT_RST;
            watched_zone_reg <= ZONE_UP;
            input_mode_reg   <= MODE_TOUCH;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CAL_X_MIN:    cal_x_min_reg    <= cfg_wr_data[COORD_W-1:0];
                REG_CAL_X_MAX:    cal_x_max_reg    <= cfg_wr_data[COORD_W-1:0];
                REG_CAL_Y_MIN:    cal_y_min_reg    <= cfg_wr_data[COORD_W-1:0];
                REG_CAL_Y_MAX:    cal_y_max_reg    <= cfg_wr_data[COORD_W-1:0];
                REG_CAL_FLAGS:    cal_flags_reg    <= cfg_wr_data[FLAGS_W-1:0];
                REG_HOLD_LIMIT:   hold_limit_reg   <= cfg_wr_data[HOLD_W-1:0];
                REG_WATCHED_ZONE: watched_zone_reg <= cfg_wr_data[1:0];
                REG_INPUT_MODE:   input_mode_reg   <= mode_t'(cfg_wr_data[1:0]);
                default:          ;
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = touched ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                if (zspan_reg)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = axis_reg ? ST_OUT : ST_MUL;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operands of the axis in work
    always_comb
    begin
        ax_raw   = axis_reg ? ry_reg : rx_reg;
        ax_lo    = axis_reg ? cal_y_min_reg : cal_x_min_reg;
        ax_hi    = axis_reg ? cal_y_max_reg : cal_x_max_reg;
        ax_last  = axis_reg ? Y_LAST : X_LAST;
        ax_inv   = axis_reg ? cal_flags_reg[FLAG_INV_Y] : cal_flags_reg[FLAG_INV_X];
        diff     = {1'b0, ax_raw} - {1'b0, ax_lo};
        span     = {1'b0, ax_hi} - {1'b0, ax_lo};
        diff_mag = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        span_mag = span[COORD_W] ? COORD_W'(-span) : span[COORD_W-1:0];
    end

    // signed quotient, optional invert, clamp to the screen
    always_comb
    begin
        q_sel    = zspan_reg ? '0 : div_quo;
        last_ext = signed'({{(EXT_W - COORD_W){1'b0}}, ax_last});
        v_sgn    = signed'({2'b00, q_sel});
        if (sign_reg)
        begin
            v_sgn = -v_sgn;
        end
        v_inv = ax_inv ? (last_ext - v_sgn) : v_sgn;
        if (v_inv < 0)
        begin
            coord = '0;
        end
        else if (v_inv > last_ext)
        begin
            coord = ax_last;
        end
        else
        begin
            coord = v_inv[COORD_W-1:0];
        end
    end

    // sample and axis datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            touched_reg <= touched;
            rx_reg      <= cal_flags_reg[FLAG_SWAP] ? raw_y : raw_x;
            ry_reg      <= cal_flags_reg[FLAG_SWAP] ? raw_x : raw_y;
            pin_reg     <= pin_level;
            now_reg     <= now_ms;
            axis_reg    <= 1'b0;
            sx_reg      <= '0;
            sy_reg      <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg  <= NUM_W'(diff_mag) * NUM_W'(ax_last);
            sign_reg  <= diff[COORD_W] ^ span[COORD_W];
            zspan_reg <= (ax_hi == ax_lo);
            span_reg  <= span_mag;
        end
        if (state_reg == ST_FIN)
        begin
            if (axis_reg)
            begin
                sy_reg <= coord;
            end
            else
            begin
                sx_reg <= coord;
            end
            axis_reg <= 1'b1;
        end
    end

    // shared divider
    tzbh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // zone from the screen row
    always_comb
    begin
        if (!touched_reg)
        begin
            zone_cur = ZONE_NONE;
        end
        else if (sy_reg < THIRD_1)
        begin
            zone_cur = ZONE_UP;
        end
        else if (sy_reg < THIRD_2)
        begin
            zone_cur = ZONE_SELECT;
        end
        else
        begin
            zone_cur = ZONE_DOWN;
        end
    end

    // press state tracker
    tzbh_btn u_btn (
        .clk          (clk),
        .rst_n        (rst_n),
        .update       (load_out),
        .touched      (touched_reg),
        .zone         (zone_cur),
        .pin_level    (pin_reg),
        .now_ms       (now_reg),
        .input_mode   (input_mode_reg),
        .watched_zone (watched_zone_reg),
        .hold_limit   (hold_limit_reg),
        .flags        (btn_flags)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_flags_reg <= btn_flags;
            out_sx_reg    <= sx_reg[SX_W-1:0];
            out_sy_reg    <= sy_reg[SY_W-1:0];
            out_zone_reg  <= zone_cur;
        end
    end

    assign out_valid     = out_valid_reg;
    assign just_pressed  = out_flags_reg.jp;
    assign just_released = out_flags_reg.jr;
    assign held          = out_flags_reg.held;
    assign screen_x      = out_sx_reg;
    assign screen_y      = out_sy_reg;
    assign zone          = out_zone_reg;

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide wait");

    // press and release edges are exclusive
    a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(just_pressed && just_released))
        else $error("press and release in one result");

    // held never reported on the press edge
    a_no_held_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && just_pressed |-> !held)
        else $error("held on press edge");

    // no touch gives a zero position
    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zone == ZONE_NONE |-> screen_x == '0 && screen_y == '0)
        else $error("position without touch");

endmodule

@@ tb/sv/touch_zone_button_hold_detector_tb.sv @@
`timescale 1ns / 1ps

module touch_zone_button_hold_detector_tb;
    import tzbh_pkg::*;

    localparam longint COL_LAST  = SCREEN_WIDTH_DEF - 1;
    localparam longint ROW_LAST  = SCREEN_HEIGHT_DEF - 1;
    localparam longint ZONE_ROWS = SCREEN_HEIGHT_DEF / 3;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     SEGMENT_POLLS   = 110;

    typedef struct packed {
        logic            jp;
        logic            jr;
        logic            held;
        logic [SX_W-1:0] sx;
        logic [SY_W-1:0] sy;
        zone_t           zone;
    } poll_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic              cfg_wr_en   = 1'b0;
    logic [2:0]        cfg_index   = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    // sample channel
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               touched   = 1'b0;
    logic [COORD_W-1:0] raw_x     = '0;
    logic [COORD_W-1:0] raw_y     = '0;
    logic               pin_level = 1'b0;
    logic [TIME_W-1:0]  now_ms    = '0;

    // result channel
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic            just_pressed;
    logic            just_released;
    logic            held;
    logic [SX_W-1:0] screen_x;
    logic [SY_W-1:0] screen_y;
    logic [1:0]      zone;

    // predicted register file
    logic [COORD_W-1:0] cal_x_lo   = '0;
    logic [COORD_W-1:0] cal_x_hi   = CAL_MAX_RST;
    logic [COORD_W-1:0] cal_y_lo   = '0;
    logic [COORD_W-1:0] cal_y_hi   = CAL_MAX_RST;
    logic [FLAGS_W-1:0] cal_opts   = '0;
    logic [HOLD_W-1:0]  hold_ms    = HOLD_LIMIT_RST;
    logic [1:0]         watch_zone = ZONE_UP;
    mode_t              in_mode    = MODE_TOUCH;

    // predicted button state
    logic              btn_down = 1'b0;
    logic [TIME_W-1:0] press_ms = '0;

    poll_result_t pending_polls[$];
    poll_result_t seen_poll;
    poll_result_t due_poll;
    int           mismatch_count = 0;

    // idling control
    int send_pct = 0;
    int stall_pct = 0;
    int hold_off_requests = 0;
    int hold_off_seen = 0;
    int hold_off_left = 0;

    touch_zone_button_hold_detector i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .touched       (touched),
        .raw_x         (raw_x),
        .raw_y         (raw_y),
        .pin_level     (pin_level),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .just_pressed  (just_pressed),
        .just_released (just_released),
        .held          (held),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .zone          (zone)
    );

    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // linear map with truncating division, zero span gives 0
    function automatic longint scale_axis(input longint raw, input longint lo,
                                          input longint hi, input longint last);
        if (hi == lo)
            return 0;
        return ((raw - lo) * last) / (hi - lo);
    endfunction

    function automatic longint clamp_axis(input longint v, input longint last);
        if (v < 0)
            return 0;
        if (v > last)
            return last;
        return v;
    endfunction

    // screen position and zone of a touch under the current calibration
    function automatic void map_touch(input logic [COORD_W-1:0] rx, input logic [COORD_W-1:0] ry,
                                      output logic [SX_W-1:0] sx, output logic [SY_W-1:0] sy,
                                      output zone_t z);
        longint ax;
        longint ay;
        longint col;
        longint row;
        ax = rx;
        ay = ry;
        if (cal_opts[FLAG_SWAP])
        begin
            ax = ry;
            ay = rx;
        end
        col = scale_axis(ax, cal_x_lo, cal_x_hi, COL_LAST);
        row = scale_axis(ay, cal_y_lo, cal_y_hi, ROW_LAST);
        if (cal_opts[FLAG_INV_X])
            col = COL_LAST - col;
        if (cal_opts[FLAG_INV_Y])
            row = ROW_LAST - row;
        col = clamp_axis(col, COL_LAST);
        row = clamp_axis(row, ROW_LAST);
        if (row < ZONE_ROWS)
            z = ZONE_UP;
        else if (row < 2 * ZONE_ROWS)
            z = ZONE_SELECT;
        else
            z = ZONE_DOWN;
        sx = col[SX_W-1:0];
        sy = row[SY_W-1:0];
    endfunction

    // expected result of one poll, advances the button state
    function automatic poll_result_t predict_poll(input logic tch, input logic [COORD_W-1:0] rx,
                                                  input logic [COORD_W-1:0] ry, input logic pin,
                                                  input logic [TIME_W-1:0] now);
        poll_result_t r;
        logic pressed;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        r.zone = ZONE_NONE;
        if (tch)
            map_touch(rx, ry, r.sx, r.sy, r.zone);
        case (in_mode)
            MODE_TOUCH:    pressed = tch && (r.zone == watch_zone);
            MODE_PIN_LOW:  pressed = !pin;
            MODE_PIN_HIGH: pressed = pin;
            default:       pressed = 1'b0;
        endcase
        r.jp = pressed && !btn_down;
        r.jr = !pressed && btn_down;
        elapsed = now - press_ms;
        if (r.jp)
            press_ms = now;
        else if (pressed)
            r.held = (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_ms});
        btn_down = pressed;
        return r;
    endfunction

    function automatic string poll_text(input poll_result_t p);
        return $sformatf("jp=%0b jr=%0b held=%0b x=%0d y=%0d zone=%0d",
                         p.jp, p.jr, p.held, p.sx, p.sy, p.zone);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    // result checking on every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen_poll = '{just_pressed, just_released, held, screen_x, screen_y, zone_t'(zone)};
            if (pending_polls.size() == 0)
                note_mismatch({"result with nothing pending: ", poll_text(seen_poll)});
            else
            begin
                due_poll = pending_polls.pop_front();
                if (seen_poll.jp !== due_poll.jp || seen_poll.jr !== due_poll.jr ||
                    seen_poll.held !== due_poll.held || seen_poll.sx !== due_poll.sx ||
                    seen_poll.sy !== due_poll.sy || seen_poll.zone !== due_poll.zone)
                    note_mismatch($sformatf("expected %s, got %s",
                                            poll_text(due_poll), poll_text(seen_poll)));
            end
        end
    end

    // receiver stall: long hold-off on request, else random per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            hold_off_left <= 0;
        end
        else if (hold_off_seen != hold_off_requests)
        begin
            hold_off_seen <= hold_off_requests;
            hold_off_left <= HOLD_OFF_CYCLES;
            out_stall     <= 1'b1;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_stall     <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic set_idle_phase(input int phase);
        case (phase)
            1:       begin send_pct = 61; stall_pct = 0;  end
            2:       begin send_pct = 0;  stall_pct = 61; end
            3:       begin send_pct = 9;  stall_pct = 9;  end
            default: begin send_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // one register write, predictor follows at the same edge
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge clk);
        case (idx)
            REG_CAL_X_MIN:    cal_x_lo   = value[COORD_W-1:0];
            REG_CAL_X_MAX:    cal_x_hi   = value[COORD_W-1:0];
            REG_CAL_Y_MIN:    cal_y_lo   = value[COORD_W-1:0];
            REG_CAL_Y_MAX:    cal_y_hi   = value[COORD_W-1:0];
            REG_CAL_FLAGS:    cal_opts   = value[FLAGS_W-1:0];
            REG_HOLD_LIMIT:   hold_ms    = value[HOLD_W-1:0];
            REG_WATCHED_ZONE: watch_zone = value[1:0];
            default:          in_mode    = mode_t'(value[1:0]);
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // one sample transfer, expectation queued at acceptance
    task automatic send_poll(input logic tch, input logic [COORD_W-1:0] rx,
                             input logic [COORD_W-1:0] ry, input logic pin,
                             input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        touched   <= tch;
        raw_x     <= rx;
        raw_y     <= ry;
        pin_level <= pin;
        now_ms    <= now;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_polls.push_back(predict_poll(tch, rx, ry, pin, now));
    endtask

    // stop offering and let every pending result come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_polls.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic pick_span(output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
        logic [COORD_W-1:0] t;
        lo = 12'($urandom_range(0, 800));
        hi = 12'($urandom_range(3300, 4095));
        if ($urandom_range(0, 3) == 0)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        if ($urandom_range(0, 9) == 0)
            hi = lo;
    endtask

    // all registers, with noise in the unused upper data bits
    task automatic load_random_setup(input int pick);
        logic [COORD_W-1:0] xl;
        logic [COORD_W-1:0] xh;
        logic [COORD_W-1:0] yl;
        logic [COORD_W-1:0] yh;
        logic [FLAGS_W-1:0] fl;
        logic [HOLD_W-1:0]  hl;
        logic [1:0]         wz;
        logic [1:0]         md;
        int                 m;
        case (pick)
            0:
            begin
                xl = 12'd0; xh = 12'd4095; yl = 12'd4095; yh = 12'd0;
                fl = 3'b111; hl = 16'd0; wz = ZONE_DOWN; md = MODE_TOUCH;
            end
            1:
            begin
                xl = 12'd4095; xh = 12'd4095; yl = 12'd0; yh = 12'd4095;
                fl = 3'b000; hl = 16'hFFFF; wz = ZONE_SELECT; md = MODE_TOUCH;
            end
            default:
            begin
                pick_span(xl, xh);
                pick_span(yl, yh);
                fl = 3'($urandom);
                case ($urandom_range(0, 3))
                    0:       hl = 16'd0;
                    1:       hl = 16'hFFFF;
                    2:       hl = HOLD_LIMIT_RST;
                    default: hl = 16'($urandom_range(1, 300));
                endcase
                wz = ($urandom_range(0, 9) == 0) ? ZONE_NONE : 2'($urandom_range(0, 2));
                m = $urandom_range(0, 9);
                if (m < 5)
                    md = MODE_TOUCH;
                else if (m < 7)
                    md = MODE_PIN_LOW;
                else if (m < 9)
                    md = MODE_PIN_HIGH;
                else
                    md = MODE_OFF;
            end
        endcase
        write_reg(REG_CAL_X_MIN, {4'($urandom), xl});
        write_reg(REG_CAL_X_MAX, {4'($urandom), xh});
        write_reg(REG_CAL_Y_MIN, {4'($urandom), yl});
        write_reg(REG_CAL_Y_MAX, {4'($urandom), yh});
        write_reg(REG_CAL_FLAGS, {13'($urandom), fl});
        write_reg(REG_HOLD_LIMIT, hl);
        write_reg(REG_WATCHED_ZONE, {14'($urandom), wz});
        write_reg(REG_INPUT_MODE, {14'($urandom), md});
    endtask

    // press and release runs with advancing time, plus some noise
    task automatic run_button_traffic(input int n_polls);
        logic               want_down;
        logic               tch;
        logic               pin;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [SX_W-1:0]    sx;
        logic [SY_W-1:0]    sy;
        zone_t              z;
        logic [TIME_W-1:0]  clock_ms;
        int                 run_left;
        want_down = 1'b0;
        run_left  = 0;
        clock_ms  = $urandom;
        for (int n = 0; n < n_polls; n++)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_poll(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                          1'($urandom_range(0, 1)), $urandom);
                continue;
            end
            if (run_left == 0)
            begin
                want_down = !want_down;
                run_left  = $urandom_range(1, 10);
            end
            run_left--;
            // time step, sometimes landing right at the hold limit
            case ($urandom_range(0, 3))
                0:       clock_ms += $urandom_range(0, 20);
                1:       clock_ms += $urandom_range(0, hold_ms + 50);
                2:       clock_ms += hold_ms;
                default:
                    if (btn_down)
                        clock_ms = press_ms + hold_ms - 1 + $urandom_range(0, 2);
                    else
                        clock_ms += $urandom_range(0, 5);
            endcase
            rx  = 12'($urandom);
            ry  = 12'($urandom);
            pin = (in_mode == MODE_PIN_HIGH) ? want_down : !want_down;
            if (in_mode == MODE_TOUCH)
            begin
                tch = want_down ? 1'b1 : 1'($urandom_range(0, 1));
                // look for a touch inside the watched zone
                if (want_down)
                    for (int k = 0; k < 16; k++)
                    begin
                        map_touch(rx, ry, sx, sy, z);
                        if (z == watch_zone)
                            break;
                        rx = 12'($urandom);
                        ry = 12'($urandom);
                    end
            end
            else
                tch = 1'($urandom_range(0, 1));
            send_poll(tch, rx, ry, pin, clock_ms);
        end
    endtask

    // default calibration: zone edges, press, hold and release, time wrap
    task automatic test_default_zones_and_hold();
        set_idle_phase(0);
        send_poll(1'b0, 12'd0,    12'd0,    1'b0, 32'd0);
        send_poll(1'b1, 12'd0,    12'd0,    1'b1, 32'd100);
        send_poll(1'b1, 12'hFFF,  12'd100,  1'b0, 32'd1000);
        send_poll(1'b1, 12'd2048, 12'd500,  1'b1, 32'd2100);
        send_poll(1'b1, 12'd0,    12'hFFF,  1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 12'd100,  12'd1360, 1'b0, 32'hFFFF_FF00);
        send_poll(1'b1, 12'd200,  12'd1000, 1'b0, 32'h0000_0700);
        send_poll(1'b1, 12'd300,  12'd1361, 1'b0, 32'h0000_0800);
        send_poll(1'b1, 12'd400,  12'd2721, 1'b1, 32'h0000_0900);
        send_poll(1'b1, 12'd500,  12'd2722, 1'b1, 32'h0000_0A00);
        wait_idle();
    endtask

    // zero span, reversed span, swap and both inversions
    task automatic test_calibration_corners();
        set_idle_phase(0);
        write_reg(REG_CAL_X_MIN, 16'd2000);
        write_reg(REG_CAL_X_MAX, 16'd2000);
        write_reg(REG_CAL_Y_MIN, 16'd4000);
        write_reg(REG_CAL_Y_MAX, 16'd100);
        write_reg(REG_CAL_FLAGS, 16'b111);
        send_poll(1'b1, 12'd0,    12'hFFF,  1'b0, 32'd10);
        send_poll(1'b1, 12'hFFF,  12'd0,    1'b0, 32'd20);
        send_poll(1'b1, 12'hAAA,  12'h555,  1'b1, 32'd30);
        wait_idle();
        write_reg(REG_CAL_FLAGS, 16'b000);
        write_reg(REG_CAL_Y_MIN, 16'hFFF);
        write_reg(REG_CAL_Y_MAX, 16'hFFF);
        send_poll(1'b1, 12'hFFF,  12'hFFF,  1'b0, 32'd40);
        send_poll(1'b1, 12'h555,  12'hAAA,  1'b1, 32'd50);
        wait_idle();
    endtask

    // pin polarities, button off, and a watched zone that no touch hits
    task automatic test_pin_and_off_modes();
        set_idle_phase(0);
        write_reg(REG_INPUT_MODE, CFG_W'(MODE_PIN_LOW));
        write_reg(REG_HOLD_LIMIT, 16'd0);
        send_poll(1'b0, 12'd0,    12'd0,    1'b1, 32'd10);
        send_poll(1'b0, 12'd0,    12'd0,    1'b0, 32'd20);
        send_poll(1'b0, 12'd0,    12'd0,    1'b0, 32'd20);
        send_poll(1'b1, 12'd0,    12'd0,    1'b1, 32'd30);
        wait_idle();
        write_reg(REG_INPUT_MODE, CFG_W'(MODE_PIN_HIGH));
        write_reg(REG_HOLD_LIMIT, 16'hFFFF);
        send_poll(1'b0, 12'd0,    12'd0,    1'b1, 32'd0);
        send_poll(1'b0, 12'd0,    12'd0,    1'b1, 32'd65535);
        send_poll(1'b0, 12'd0,    12'd0,    1'b0, 32'd65600);
        wait_idle();
        write_reg(REG_INPUT_MODE, CFG_W'(MODE_OFF));
        send_poll(1'b1, 12'd0,    12'd0,    1'b0, 32'd1);
        send_poll(1'b1, 12'd0,    12'd0,    1'b1, 32'd2);
        wait_idle();
        write_reg(REG_INPUT_MODE, CFG_W'(MODE_TOUCH));
        write_reg(REG_WATCHED_ZONE, CFG_W'(ZONE_NONE));
        write_reg(REG_CAL_Y_MIN, 16'd0);
        write_reg(REG_CAL_Y_MAX, 16'hFFF);
        send_poll(1'b1, 12'd100,  12'd0,    1'b0, 32'd3);
        send_poll(1'b0, 12'd0,    12'd0,    1'b0, 32'd4);
        wait_idle();
    endtask

    // receiver holds off long enough for the input to back up
    task automatic test_output_backpressure();
        set_idle_phase(0);
        load_random_setup(2);
        hold_off_requests++;
        run_button_traffic(40);
        wait_idle();
    endtask

    // random setups, every idling phase
    task automatic test_random_traffic();
        for (int seg = 0; seg < 8; seg++)
        begin
            set_idle_phase(seg % 4);
            load_random_setup(seg);
            run_button_traffic(SEGMENT_POLLS);
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_zones_and_hold();
        test_calibration_corners();
        test_pin_and_off_modes();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
